FILE: hw/rtl/nfa_pkg.sv
// shared constants, operation codes and the control struct for the nfa state set matcher
`default_nettype none

package nfa_pkg;

  localparam int NFA_NUM_STATES  = 32;
  localparam int NFA_NUM_SYMBOLS = 16;

  localparam int STATE_W     = 5;
  localparam int SYM_FIELD_W = 4;
  localparam int MASK_W      = 32;
  localparam int CFG_W       = 5;
  localparam int CFG_IDX_W   = 1;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_BEGIN  = 2'd1,
    OP_SYMBOL = 2'd2,
    OP_END    = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START  = 1'd0,
    CFG_ACCEPT = 1'd1
  } cfg_idx_t;

  // write and read requests into the transition store
  typedef struct packed {
    logic                   wr_en;
    logic [STATE_W-1:0]     wr_state;
    logic [SYM_FIELD_W-1:0] wr_sym;
    logic                   rd_en;
    logic [SYM_FIELD_W-1:0] rd_sym;
  } ts_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/nfa_if.sv
// valid/ready channel interfaces for input words and result words
`default_nettype none

interface nfa_in_if;
  import nfa_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             operation;
  logic [STATE_W-1:0]     state_index;
  logic [SYM_FIELD_W-1:0] symbol;
  logic [MASK_W-1:0]      dest_mask;

  modport source (output valid, output operation, output state_index, output symbol,
                  output dest_mask, input ready);
  modport sink   (input valid, input operation, input state_index, input symbol,
                  input dest_mask, output ready);
endinterface

interface nfa_out_if;
  logic valid;
  logic ready;
  logic accepted;

  modport source (output valid, output accepted, input ready);
  modport sink   (input valid, input accepted, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/nfa_state_set_matcher_unit.sv
// top level: nfa subset simulation over a banked transition store
// an accepted word is registered in the stage register; an end word's result is then
// registered in the result register that drives out_ch.
// throughput: one word per cycle when not stalled; a symbol reads one row from every state bank at once.
// stall: an end word waiting on a full result register holds the input side, as does the store's reset sweep.
// reset: synchronous active low; the transition store is swept to zero, one symbol slot
// per cycle, during which no word is accepted.
`default_nettype none

module nfa_state_set_matcher_unit
  import nfa_pkg::*;
#(
  parameter int NUM_STATES  = NFA_NUM_STATES,
  parameter int NUM_SYMBOLS = NFA_NUM_SYMBOLS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  nfa_in_if.sink                    in_ch,
  nfa_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  logic [CFG_W-1:0] cfg_start_r;
  logic [CFG_W-1:0] cfg_accept_r;

  logic                  s1_valid_r;
  op_t                   s1_op_r;
  logic                  s1_sym_ok_r;
  logic [NUM_STATES-1:0] active_r;
  logic                  out_valid_r;
  logic                  out_accepted_r;

  op_t                   in_op;
  logic                  in_accept;
  logic                  in_sym_ok;
  logic                  in_state_ok;
  logic                  s1_adv;
  logic                  busy;
  ts_ctrl_t              ts_ctrl;
  logic [NUM_STATES-1:0] wr_mask;
  logic [NUM_STATES-1:0][NUM_STATES-1:0] rows;
  logic [NUM_STATES-1:0] next_set;
  logic [NUM_STATES-1:0] begin_set;
  logic                  acc_bit;

  assign in_op       = op_t'(in_ch.operation);
  assign in_sym_ok   = 32'(in_ch.symbol) < NUM_SYMBOLS;
  assign in_state_ok = 32'(in_ch.state_index) < NUM_STATES;

  // an end word in the stage needs a free result slot to move on
  assign s1_adv    = !s1_valid_r || (s1_op_r != OP_END) || !out_valid_r || out_ch.ready;
  assign in_ch.ready = s1_adv && !busy;
  assign in_accept = in_ch.valid && in_ch.ready;

  // mask bits past the last state are dropped
  for (genvar i = 0; i < NUM_STATES; i++) begin : g_mask
    if (i < MASK_W) begin : g_in
      assign wr_mask[i] = in_ch.dest_mask[i];
    end else begin : g_zero
      assign wr_mask[i] = 1'b0;
    end
  end

  always_comb begin
    ts_ctrl.wr_en    = in_accept && (in_op == OP_LOAD) && in_sym_ok && in_state_ok;
    ts_ctrl.wr_state = in_ch.state_index;
    ts_ctrl.wr_sym   = in_ch.symbol;
    ts_ctrl.rd_en    = in_accept && (in_op == OP_SYMBOL);
    ts_ctrl.rd_sym   = in_ch.symbol;
  end

  nfa_trans_store #(
    .NUM_STATES (NUM_STATES),
    .NUM_SYMBOLS(NUM_SYMBOLS)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ts_ctrl),
    .wr_mask(wr_mask),
    .rows   (rows),
    .busy   (busy)
  );

  nfa_set_update #(
    .NUM_STATES(NUM_STATES)
  ) u_update (
    .active      (active_r),
    .rows        (rows),
    .sym_ok      (s1_sym_ok_r),
    .start_state (cfg_start_r),
    .accept_state(cfg_accept_r),
    .next_set    (next_set),
    .begin_set   (begin_set),
    .accepted    (acc_bit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_start_r  <= '0;
      cfg_accept_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_START:  cfg_start_r  <= cfg_wdata;
        CFG_ACCEPT: cfg_accept_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_op_r     <= in_op;
      s1_sym_ok_r <= in_sym_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (s1_valid_r && s1_adv) begin
      case (s1_op_r)
        OP_BEGIN:  active_r <= begin_set;
        OP_SYMBOL: active_r <= next_set;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid_r && s1_adv && (s1_op_r == OP_END)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv && (s1_op_r == OP_END)) begin
      out_accepted_r <= acc_bit;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.accepted = out_accepted_r;

endmodule

`default_nettype wire

FILE: hw/rtl/nfa_ram.sv
// generic single write port ram with registered read
`default_nettype none

module nfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/nfa_trans_store.sv
// transition store: one ram bank per source state, indexed by symbol, cleared after reset
`default_nettype none

module nfa_trans_store
  import nfa_pkg::*;
#(
  parameter int NUM_STATES  = NFA_NUM_STATES,
  parameter int NUM_SYMBOLS = NFA_NUM_SYMBOLS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire ts_ctrl_t                              ctrl,
  input  wire logic [NUM_STATES-1:0]                 wr_mask,
  output logic      [NUM_STATES-1:0][NUM_STATES-1:0] rows,
  output logic                                       busy
);

  localparam int SYM_W = $clog2(NUM_SYMBOLS);

  logic             clr_r;
  logic             clr_nxt;
  logic [SYM_W-1:0] clr_addr_r;
  logic [SYM_W-1:0] clr_addr_nxt;
  logic [SYM_W-1:0] waddr;
  logic [SYM_W-1:0] raddr;
  logic [NUM_STATES-1:0] wdata;

  // one row per cycle across all banks until every symbol slot is zero
  always_comb begin
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      clr_addr_nxt = clr_addr_r + SYM_W'(1);
      if (clr_addr_r == SYM_W'(NUM_SYMBOLS - 1)) begin
        clr_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  assign busy  = clr_r;
  assign waddr = clr_r ? clr_addr_r : ctrl.wr_sym[SYM_W-1:0];
  assign wdata = clr_r ? '0 : wr_mask;
  assign raddr = ctrl.rd_sym[SYM_W-1:0];

  for (genvar s = 0; s < NUM_STATES; s++) begin : g_bank
    logic bank_we;
    assign bank_we = clr_r || (ctrl.wr_en && (32'(ctrl.wr_state) == s));

    nfa_ram #(
      .WIDTH(NUM_STATES),
      .DEPTH(NUM_SYMBOLS)
    ) u_bank (
      .clk  (clk),
      .we   (bank_we),
      .waddr(waddr),
      .wdata(wdata),
      .re   (ctrl.rd_en),
      .raddr(raddr),
      .rdata(rows[s])
    );
  end

endmodule

`default_nettype wire

FILE: hw/rtl/nfa_set_update.sv
// next active set, begin set and accept test from the current active set
`default_nettype none

module nfa_set_update
  import nfa_pkg::*;
#(
  parameter int NUM_STATES = NFA_NUM_STATES
) (
  input  wire logic [NUM_STATES-1:0]                 active,
  input  wire logic [NUM_STATES-1:0][NUM_STATES-1:0] rows,
  input  wire logic                                  sym_ok,
  input  wire logic [CFG_W-1:0]                      start_state,
  input  wire logic [CFG_W-1:0]                      accept_state,
  output logic      [NUM_STATES-1:0]                 next_set,
  output logic      [NUM_STATES-1:0]                 begin_set,
  output logic                                       accepted
);

  logic [NUM_STATES-1:0][NUM_STATES-1:0] cols;
  logic [NUM_STATES-1:0]                 acc_hit;

  always_comb begin
    for (int d = 0; d < NUM_STATES; d++) begin
      for (int s = 0; s < NUM_STATES; s++) begin
        cols[d][s] = rows[s][d];
      end
    end
    for (int d = 0; d < NUM_STATES; d++) begin
      next_set[d] = sym_ok && (|(active & cols[d]));
    end
    // out of range start or accept simply matches no state
    for (int s = 0; s < NUM_STATES; s++) begin
      begin_set[s] = (32'(start_state) == 32'(s));
      acc_hit[s]   = active[s] && (32'(accept_state) == 32'(s));
    end
  end

  assign accepted = |acc_hit;

endmodule

`default_nettype wire
